/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the sequencer's RTL files.
// Every macro samples on clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define NFCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define NFCS_ASSERT_NEVER(label, cond, msg) \
  `NFCS_ASSERT(label, !(cond), msg)

`endif

/* hw/rtl/nfcs_pkg.sv */
// Shared constants, codes and control structs of the NAND command sequencer.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
package nfcs_pkg;

  // Store geometry and field widths.
  localparam int STORE_BYTES = 65536;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int MAX_BURST   = 32;
  localparam int CNT_W       = 6;
  localparam int REM_W       = CNT_W + 1;
  localparam int ADDR_W      = 32;
  localparam int OFF_W       = ADDR_W + 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MANUF_ID          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_READ_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_BUS          = 2'd3;

  localparam logic [7:0] MANUF_ID_RESET  = 8'hEC;
  localparam logic [7:0] DEVICE_ID_RESET = 8'h76;
  localparam logic [7:0] ERASED_BYTE     = 8'hFF;

  // Bus event kinds.
  localparam logic [1:0] EV_COMMAND = 2'd0;
  localparam logic [1:0] EV_ADDRESS = 2'd1;
  localparam logic [1:0] EV_READ    = 2'd2;
  localparam logic [1:0] EV_WRITE   = 2'd3;

  // Command opcodes.
  localparam logic [7:0] OP_RESET       = 8'hFF;
  localparam logic [7:0] OP_READ        = 8'h00;
  localparam logic [7:0] OP_READ_START  = 8'h30;
  localparam logic [7:0] OP_READID      = 8'h90;
  localparam logic [7:0] OP_PROGRAM     = 8'h80;
  localparam logic [7:0] OP_PROGRAM_END = 8'h10;
  localparam logic [7:0] OP_ERASE       = 8'h60;

  // How an executed event finishes.
  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_BURST  = 2'd2;

  typedef struct packed {
    logic ready;
    logic clear;
    logic calc_base;
    logic calc_off;
    logic exec;
    logic mem_wr;
    logic emit_single;
    logic rd_issue;
    logic rd_emit;
  } nfcs_cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       out_free;
    logic       burst_last;
    logic [1:0] kind;
  } nfcs_sts_t;

endpackage

/* hw/rtl/nfcs_if.sv */
// Valid/ready channel interfaces for bus events and result words.
// Depends on nfcs_pkg for field widths.
interface nfcs_evt_if;
  import nfcs_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [7:0]       value;
  logic [CNT_W-1:0] read_count;
  modport source (output valid, output cmd, output value, output read_count, input ready);
  modport sink (input valid, input cmd, input value, input read_count, output ready);
endinterface

interface nfcs_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       status;
  logic       last;
  modport source (output valid, output data_byte, output status, output last, input ready);
  modport sink (input valid, input data_byte, input status, input last, output ready);
endinterface

/* hw/rtl/nand_flash_command_sequencer_unit.sv */
// Top level of the NAND flash command sequencer.
// Depends on nfcs_pkg, nfcs_if (channel interfaces), nfcs_ctrl and nfcs_dp.
//
// Usage: bus events enter on the evt channel (cmd, value, read_count), one word per
// event. Every event yields one or more result words on the res channel
// (data_byte, status, last); the final word of an event carries last = 1.
// Configuration registers (manufacturer id, device id, read-start enable, wide bus)
// are written via cfg_we/cfg_index/cfg_data, by the user only in idle (unenforced).
//
// Sequence: an event is accepted only in idle, then passes through states for
// the base offset, the offset with write index, the decision and the result load.
// A command, address or rejected event is back in idle after the result load,
// which waits while the receiver stalls. A program write adds a state for the
// read-modify-write of the store. A read burst alternates per byte between the
// registered memory read and the load of the result register, which also waits.
// The offset adders and the single store port set this order of states.
//
// Reset: rst clears the sequencer and then sweeps all 65536 bytes of the store to
// 0xFF, one byte per cycle; no event is accepted during the sweep. A stalled
// receiver holds the result register and the block waits until it drains.
module nand_flash_command_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  nfcs_evt_if.sink                        evt,
  nfcs_res_if.source                      res,
  input  logic                            cfg_we,
  input  logic [nfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nfcs_pkg::*;

  nfcs_cmd_t ctl;
  nfcs_sts_t sts;
  logic      accept;

  // The event channel is open only while the controller sits in idle.
  assign evt.ready = ctl.ready;
  assign accept    = evt.valid && ctl.ready;

  nfcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sts    (sts),
    .ctl    (ctl)
  );

  // The datapath owns the result register; it drives the res channel directly.
  nfcs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .accept         (accept),
    .evt_cmd        (evt.cmd),
    .evt_value      (evt.value),
    .evt_read_count (evt.read_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .res_ready      (res.ready),
    .res_valid      (res.valid),
    .res_data_byte  (res.data_byte),
    .res_status     (res.status),
    .res_last       (res.last),
    .sts            (sts)
  );

endmodule

/* hw/rtl/nfcs_ctrl.sv */
// Controller state machine of the NAND command sequencer.
// Depends on nfcs_pkg and assert_macros.svh; drives the datapath by command struct.
`include "assert_macros.svh"

module nfcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  nfcs_pkg::nfcs_sts_t  sts,
  output nfcs_pkg::nfcs_cmd_t  ctl
);
  import nfcs_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_BASE     = 4'd2;
  localparam logic [3:0] S_OFFS     = 4'd3;
  localparam logic [3:0] S_EXEC     = 4'd4;
  localparam logic [3:0] S_WRITE    = 4'd5;
  localparam logic [3:0] S_EMIT     = 4'd6;
  localparam logic [3:0] S_RD_ISSUE = 4'd7;
  localparam logic [3:0] S_RD_DATA  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl.ready = 1'b1;
        if (accept) begin
          state_next = S_BASE;
        end
      end
      S_BASE: begin
        ctl.calc_base = 1'b1;
        state_next    = S_OFFS;
      end
      S_OFFS: begin
        ctl.calc_off = 1'b1;
        state_next   = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        unique case (sts.kind)
          KIND_WRITE: state_next = S_WRITE;
          KIND_BURST: state_next = S_RD_ISSUE;
          default:    state_next = S_EMIT;
        endcase
      end
      S_WRITE: begin
        ctl.mem_wr = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        ctl.rd_issue = 1'b1;
        state_next   = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (sts.out_free) begin
          ctl.rd_emit = 1'b1;
          state_next  = sts.burst_last ? S_IDLE : S_RD_ISSUE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `NFCS_ASSERT(a_accept_starts_item, accept |=> state == S_BASE, "accepted word did not start")
  `NFCS_ASSERT(a_write_after_exec, state == S_WRITE |-> $past(state == S_EXEC), "bad write entry")
  `NFCS_ASSERT(a_state_legal, state <= S_RD_DATA, "illegal controller state")

endmodule

/* hw/rtl/nfcs_dp.sv */
// Datapath of the NAND command sequencer: sequencing flags, address and offset
// arithmetic, the flash store, configuration registers and the result register.
// Depends on nfcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nfcs_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  nfcs_pkg::nfcs_cmd_t                   ctl,
  input  logic                                  accept,
  input  logic [1:0]                            evt_cmd,
  input  logic [7:0]                            evt_value,
  input  logic [nfcs_pkg::CNT_W-1:0]            evt_read_count,
  input  logic                                  cfg_we,
  input  logic [nfcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nfcs_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  res_ready,
  output logic                                  res_valid,
  output logic [7:0]                            res_data_byte,
  output logic                                  res_status,
  output logic                                  res_last,
  output nfcs_pkg::nfcs_sts_t                   sts
);
  import nfcs_pkg::*;

  // Latched event.
  logic [1:0]       ev_kind;
  logic [7:0]       ev_value;
  logic [CNT_W-1:0] ev_count;

  // Configuration.
  logic [7:0] manuf_id;
  logic [7:0] device_id;
  logic       expect_read_start;
  logic       wide_bus;

  // Sequencer state.
  logic              start_ok, exp_cmd, exp_addr, exp_read, exp_write;
  logic [7:0]        cmd0;
  logic [1:0]        cmd_count;
  logic [ADDR_W-1:0] addr_word;
  logic [2:0]        addr_count;
  logic [15:0]       write_index;

  logic              start_ok_next, exp_cmd_next, exp_addr_next, exp_read_next;
  logic              exp_write_next;
  logic [7:0]        cmd0_next;
  logic [1:0]        cmd_count_next;
  logic [ADDR_W-1:0] addr_word_next;
  logic [2:0]        addr_count_next;
  logic [15:0]       write_index_next;

  // Outcome of the executed event.
  logic             exec_idle, exec_status, exec_id;
  logic [1:0]       exec_kind;
  logic [REM_W-1:0] exec_rem;

  logic [OFF_W-1:0] base_q, off_q, off_end;
  logic [REM_W-1:0] bytes;
  logic             range_bad, wr_bad;
  logic [7:0]       op_first;
  logic             second_cmd;

  // Burst and result staging.
  logic [AW-1:0]    ptr;
  logic [REM_W-1:0] rem;
  logic             id_mode, id_first, st_q;
  logic             out_free;

  // Flash store.
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rdata;
  logic [AW-1:0] clr_addr;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_kind  <= evt_cmd;
      ev_value <= evt_value;
      ev_count <= evt_read_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manuf_id          <= MANUF_ID_RESET;
      device_id         <= DEVICE_ID_RESET;
      expect_read_start <= 1'b0;
      wide_bus          <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MANUF_ID:          manuf_id          <= cfg_data;
        CFG_DEVICE_ID:         device_id         <= cfg_data;
        CFG_EXPECT_READ_START: expect_read_start <= cfg_data[0];
        CFG_WIDE_BUS:          wide_bus          <= cfg_data[0];
        default:               manuf_id          <= manuf_id;
      endcase
    end
  end

  // Offset arithmetic is registered in steps: base, then base plus write index.
  always_ff @(posedge clk) begin
    if (ctl.calc_base) begin
      base_q <= OFF_W'(addr_word) + (OFF_W'(addr_word[ADDR_W-1:8]) << 4);
    end
    if (ctl.calc_off) begin
      off_q <= base_q + ((ev_kind == EV_WRITE) ? OFF_W'(write_index) : '0);
    end
  end

  assign bytes      = wide_bus ? {ev_count, 1'b0} : {1'b0, ev_count};
  assign off_end    = off_q + OFF_W'(bytes);
  assign range_bad  = off_end > OFF_W'(STORE_BYTES);
  assign wr_bad     = off_q >= OFF_W'(STORE_BYTES);
  assign op_first   = (cmd_count == 2'd0) ? ev_value : cmd0;
  assign second_cmd = cmd_count != 2'd0;

  always_comb begin
    start_ok_next    = start_ok;
    exp_cmd_next     = exp_cmd;
    exp_addr_next    = exp_addr;
    exp_read_next    = exp_read;
    exp_write_next   = exp_write;
    cmd0_next        = cmd0;
    cmd_count_next   = cmd_count;
    addr_word_next   = addr_word;
    addr_count_next  = addr_count;
    write_index_next = write_index;
    exec_idle        = 1'b0;
    exec_status      = 1'b0;
    exec_kind        = KIND_SINGLE;
    exec_rem         = '0;
    exec_id          = 1'b0;
    unique case (ev_kind)
      EV_COMMAND: begin
        if (ev_value == OP_RESET) begin
          exec_idle = 1'b1;
        end else if (!(start_ok || exp_cmd) || cmd_count >= 2'd2) begin
          exec_idle   = 1'b1;
          exec_status = 1'b1;
        end else begin
          start_ok_next  = 1'b0;
          cmd0_next      = op_first;
          cmd_count_next = cmd_count + 2'd1;
          exp_cmd_next   = 1'b0;
          exp_addr_next  = 1'b0;
          exp_read_next  = 1'b0;
          exp_write_next = 1'b0;
          unique case (op_first)
            OP_PROGRAM: begin
              if (!second_cmd) begin
                exp_addr_next = 1'b1;
              end else begin
                exec_idle   = 1'b1;
                exec_status = ev_value != OP_PROGRAM_END;
              end
            end
            OP_READ: begin
              if (!second_cmd) begin
                exp_addr_next = 1'b1;
              end else if (ev_value != OP_READ_START || !expect_read_start) begin
                exec_idle   = 1'b1;
                exec_status = 1'b1;
              end else begin
                exp_read_next = 1'b1;
              end
            end
            OP_ERASE: begin
              exp_addr_next = 1'b1;
            end
            OP_READID: begin
              if (second_cmd) begin
                exec_idle   = 1'b1;
                exec_status = 1'b1;
              end else begin
                exp_addr_next = 1'b1;
              end
            end
            default: begin
              exec_idle   = 1'b1;
              exec_status = 1'b1;
            end
          endcase
        end
      end
      EV_ADDRESS: begin
        if (!exp_addr || addr_count >= 3'd4) begin
          exec_idle   = 1'b1;
          exec_status = 1'b1;
        end else begin
          unique case (cmd0)
            OP_READID: begin
              exp_cmd_next   = 1'b0;
              exp_addr_next  = 1'b0;
              exp_read_next  = 1'b1;
              exp_write_next = 1'b0;
            end
            OP_READ: begin
              exp_cmd_next   = expect_read_start;
              exp_addr_next  = 1'b1;
              exp_read_next  = 1'b1;
              exp_write_next = 1'b0;
            end
            OP_PROGRAM: begin
              exp_cmd_next   = 1'b1;
              exp_addr_next  = 1'b1;
              exp_read_next  = 1'b0;
              exp_write_next = 1'b1;
            end
            default: begin
              exec_idle   = 1'b1;
              exec_status = 1'b1;
            end
          endcase
          addr_word_next  = addr_word | (ADDR_W'(ev_value) << {addr_count[1:0], 3'b000});
          addr_count_next = addr_count + 3'd1;
        end
      end
      EV_WRITE: begin
        if (!exp_write || cmd0 != OP_PROGRAM || wr_bad) begin
          exec_idle   = 1'b1;
          exec_status = 1'b1;
        end else begin
          write_index_next = write_index + 16'd1;
          exp_cmd_next     = 1'b1;
          exp_addr_next    = 1'b0;
          exp_read_next    = 1'b0;
          exp_write_next   = 1'b1;
          exec_kind        = KIND_WRITE;
        end
      end
      EV_READ: begin
        exec_idle = 1'b1;
        if (!exp_read) begin
          exec_status = 1'b1;
        end else if (cmd0 == OP_READID) begin
          if (addr_word != '0 || ev_count == '0) begin
            exec_status = 1'b1;
          end else begin
            exec_kind = KIND_BURST;
            exec_id   = 1'b1;
            exec_rem  = (ev_count > CNT_W'(1)) ? REM_W'(2) : REM_W'(1);
          end
        end else if (cmd0 != OP_READ || ev_count > CNT_W'(MAX_BURST) || range_bad) begin
          exec_status = 1'b1;
        end else if (bytes != '0) begin
          exec_kind = KIND_BURST;
          exec_rem  = bytes;
        end
      end
      default: begin
        exec_idle = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.exec && exec_idle)) begin
      start_ok    <= 1'b1;
      exp_cmd     <= 1'b0;
      exp_addr    <= 1'b0;
      exp_read    <= 1'b0;
      exp_write   <= 1'b0;
      cmd0        <= '0;
      cmd_count   <= '0;
      addr_word   <= '0;
      addr_count  <= '0;
      write_index <= '0;
    end else if (ctl.exec) begin
      start_ok    <= start_ok_next;
      exp_cmd     <= exp_cmd_next;
      exp_addr    <= exp_addr_next;
      exp_read    <= exp_read_next;
      exp_write   <= exp_write_next;
      cmd0        <= cmd0_next;
      cmd_count   <= cmd_count_next;
      addr_word   <= addr_word_next;
      addr_count  <= addr_count_next;
      write_index <= write_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      ptr      <= off_q[AW-1:0];
      rem      <= exec_rem;
      id_mode  <= exec_id;
      id_first <= 1'b1;
      st_q     <= exec_status;
    end else if (ctl.rd_emit) begin
      ptr      <= ptr + AW'(1);
      rem      <= rem - REM_W'(1);
      id_first <= 1'b0;
    end
  end

  // Store: clearing sweep after reset, read-modify-write for program data.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign mem_we    = ctl.clear || ctl.mem_wr;
  assign mem_waddr = ctl.clear ? clr_addr : ptr;
  assign mem_wdata = ctl.clear ? ERASED_BYTE : (rdata & ev_value);
  assign mem_re    = ctl.exec || ctl.rd_issue;
  assign mem_raddr = ctl.rd_issue ? ptr : off_q[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Result register.
  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit_single || ctl.rd_emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_single) begin
      res_data_byte <= '0;
      res_status    <= st_q;
      res_last      <= 1'b1;
    end else if (ctl.rd_emit) begin
      res_data_byte <= id_mode ? (id_first ? manuf_id : device_id) : rdata;
      res_status    <= 1'b0;
      res_last      <= rem == REM_W'(1);
    end
  end

  assign sts.clear_last = clr_addr == AW'(STORE_BYTES - 1);
  assign sts.out_free   = out_free;
  assign sts.burst_last = rem == REM_W'(1);
  assign sts.kind       = exec_kind;

  `NFCS_ASSERT_NEVER(a_burst_underrun, ctl.rd_emit && rem == '0, "burst emitted with no bytes left")
  `NFCS_ASSERT(a_result_from_emit, $rose(res_valid) |-> $past(ctl.emit_single || ctl.rd_emit), "stray result")
  `NFCS_ASSERT_NEVER(a_emit_on_busy, (ctl.emit_single || ctl.rd_emit) && !out_free, "result overwritten")

endmodule

/* tb/tb.sv */
// Self-checking testbench for nand_flash_command_sequencer_unit.
// Depends on nfcs_pkg and the channel interfaces of nfcs_if. It mirrors the command
// sequencer and its flash store in plain SystemVerilog and checks every result word.
`timescale 1ns / 100ps

module tb;
  import nfcs_pkg::*;

  // The slowest correct run is the store sweep after reset and some 300 events of
  // up to 64 words each, with a heavily stalled receiver. The limit leaves a wide
  // margin over that.
  localparam int              RUN_LIMIT   = 2_000_000;
  localparam int              HOLD_CYCLES = 400;
  localparam int              SETTLE      = 10;
  localparam int              SHOWN_FAULTS = 10;
  localparam longint unsigned FLASH_SIZE  = STORE_BYTES;

  // One bus event as it is queued for the driver.
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       value;
    logic [CNT_W-1:0] count;
  } bus_word_t;

  // One result word as the block should return it.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       status;
    logic       last;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every block input gets a known value from time zero through these initializers.
  logic                  evt_valid = 1'b0;
  logic [1:0]            evt_cmd   = EV_COMMAND;
  logic [7:0]            evt_value = 8'd0;
  logic [CNT_W-1:0]      evt_count = '0;
  logic                  res_rdy   = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MANUF_ID;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  nfcs_evt_if evt_ch ();
  nfcs_res_if res_ch ();

  assign evt_ch.valid      = evt_valid;
  assign evt_ch.cmd        = evt_cmd;
  assign evt_ch.value      = evt_value;
  assign evt_ch.read_count = evt_count;
  assign res_ch.ready      = res_rdy;

  nand_flash_command_sequencer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Traffic bookkeeping. The stimulus process fills bus_backlog. The driver offers
  // its words one at a time, and the monitor counts acceptances. A word is still
  // on the bus while events_taken trails events_offered.
  bus_word_t   bus_backlog[$];
  res_word_t   owed_words[$];
  bus_word_t   next_word;
  res_word_t   due;
  int unsigned queued_events  = 0;
  int unsigned events_offered = 0;
  int unsigned events_taken   = 0;
  int unsigned word_faults    = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 20;
  int unsigned recv_idle_pct  = 76;

  // The stimulus process bumps hold_req. The receiver notices the change and then
  // counts its own hold-off.
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Mirror of the sequencer: expectation flags, command bytes, address, write index,
  // the register settings and the whole flash store.
  logic        idle_start;
  logic        want_cmd, want_addr, want_read, want_write;
  logic [7:0]  op_code [2];
  logic [1:0]  op_count;
  logic [31:0] addr_reg;
  logic [2:0]  addr_bytes;
  logic [15:0] wr_index;
  logic [7:0]  id_manuf, id_device;
  logic        read_start_en, wide_cells;
  logic [7:0]  flash_image [0:STORE_BYTES-1];

  // ---------------------------------------------------------------------------------
  // Sequencer mirror
  // ---------------------------------------------------------------------------------

  // Returning to idle clears all sequencing state. The store is kept.
  function automatic void seq_to_idle();
    idle_start = 1'b1;
    want_cmd   = 1'b0;
    want_addr  = 1'b0;
    want_read  = 1'b0;
    want_write = 1'b0;
    op_code[0] = 8'd0;
    op_code[1] = 8'd0;
    op_count   = 2'd0;
    addr_reg   = 32'd0;
    addr_bytes = 3'd0;
    wr_index   = 16'd0;
  endfunction

  function automatic logic seq_fault();
    seq_to_idle();
    return 1'b1;
  endfunction

  function automatic void set_expect(logic c, logic a, logic r, logic w);
    want_cmd   = c;
    want_addr  = a;
    want_read  = r;
    want_write = w;
  endfunction

  // Each 256-byte page is followed by 16 spare bytes, so the store offset of an
  // address skips 16 bytes for every page below it.
  function automatic longint unsigned page_offset();
    longint unsigned a;
    a = longint'(addr_reg);
    return a + (a / 256) * 16;
  endfunction

  function automatic void owe_word(logic [7:0] d, logic s, logic l);
    res_word_t w;
    w.data_byte = d;
    w.status    = s;
    w.last      = l;
    owed_words.push_back(w);
  endfunction

  function automatic logic on_command(logic [7:0] op);
    logic [7:0] second;
    if (op == OP_RESET) begin
      seq_to_idle();
      return 1'b0;
    end
    // The first command after idle is always welcome.
    if (idle_start) begin
      idle_start = 1'b0;
      want_cmd   = 1'b1;
    end
    if (!want_cmd || op_count >= 2'd2) return seq_fault();
    op_code[op_count[0]] = op;
    op_count = op_count + 2'd1;
    set_expect(1'b0, 1'b0, 1'b0, 1'b0);
    case (op_code[0])
      OP_PROGRAM: begin
        if (op_count == 2'd1) begin
          set_expect(1'b0, 1'b1, 1'b0, 1'b0);
          return 1'b0;
        end
        // The second byte always closes the program. Only program end closes it cleanly.
        second = op_code[1];
        seq_to_idle();
        return second != OP_PROGRAM_END;
      end
      OP_READ: begin
        if (op_count == 2'd1) begin
          set_expect(1'b0, 1'b1, 1'b0, 1'b0);
          return 1'b0;
        end
        if (op_code[1] != OP_READ_START || !read_start_en) return seq_fault();
        set_expect(1'b0, 1'b0, 1'b1, 1'b0);
        return 1'b0;
      end
      OP_ERASE: begin
        // Erase waits for an address that it will then refuse.
        set_expect(1'b0, 1'b1, 1'b0, 1'b0);
        return 1'b0;
      end
      OP_READID: begin
        if (op_count > 2'd1) return seq_fault();
        set_expect(1'b0, 1'b1, 1'b0, 1'b0);
        return 1'b0;
      end
      default: return seq_fault();
    endcase
  endfunction

  function automatic logic on_address(logic [7:0] v);
    if (!want_addr || addr_bytes >= 3'd4) return seq_fault();
    case (op_code[0])
      OP_READID:  set_expect(1'b0, 1'b0, 1'b1, 1'b0);
      OP_READ:    set_expect(read_start_en, 1'b1, 1'b1, 1'b0);
      OP_PROGRAM: set_expect(1'b1, 1'b1, 1'b0, 1'b1);
      default:    return seq_fault();
    endcase
    // Address bytes arrive least significant first.
    addr_reg   = addr_reg | ({24'd0, v} << (8 * addr_bytes));
    addr_bytes = addr_bytes + 3'd1;
    return 1'b0;
  endfunction

  function automatic logic on_write(logic [7:0] v);
    longint unsigned off;
    if (!want_write || op_code[0] != OP_PROGRAM) return seq_fault();
    off = page_offset() + longint'(wr_index);
    if (off + 1 > FLASH_SIZE) return seq_fault();
    // Programming can only pull bits from one to zero.
    flash_image[off] = flash_image[off] & v;
    wr_index = wr_index + 16'd1;
    set_expect(1'b1, 1'b0, 1'b0, 1'b1);
    return 1'b0;
  endfunction

  function automatic void burst_fault();
    seq_to_idle();
    owe_word(8'd0, 1'b1, 1'b1);
  endfunction

  function automatic void on_burst(logic [CNT_W-1:0] n);
    longint unsigned off, nbytes, i;
    if (!want_read) begin
      burst_fault();
      return;
    end
    set_expect(1'b0, 1'b0, 1'b0, 1'b0);
    if (op_code[0] == OP_READID) begin
      if (addr_reg != 32'd0 || n == '0) begin
        burst_fault();
        return;
      end
      if (n > 1) begin
        owe_word(id_manuf, 1'b0, 1'b0);
        owe_word(id_device, 1'b0, 1'b1);
      end else begin
        owe_word(id_manuf, 1'b0, 1'b1);
      end
      seq_to_idle();
      return;
    end
    if (op_code[0] != OP_READ || n > MAX_BURST) begin
      burst_fault();
      return;
    end
    off    = page_offset();
    nbytes = wide_cells ? longint'(n) * 2 : longint'(n);
    if (off + nbytes > FLASH_SIZE) begin
      burst_fault();
      return;
    end
    seq_to_idle();
    if (nbytes == 0) begin
      owe_word(8'd0, 1'b0, 1'b1);
    end else begin
      for (i = 0; i < nbytes; i++) begin
        owe_word(flash_image[off + i], 1'b0, (i + 1) == nbytes);
      end
    end
  endfunction

  // One accepted bus event in, the result words it owes out.
  function automatic void step_sequencer(logic [1:0] kind, logic [7:0] v,
                                         logic [CNT_W-1:0] n);
    case (kind)
      EV_COMMAND: owe_word(8'd0, on_command(v), 1'b1);
      EV_ADDRESS: owe_word(8'd0, on_address(v), 1'b1);
      EV_READ:    on_burst(n);
      default:    owe_word(8'd0, on_write(v), 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------------
  // Driver, receiver, monitor, watchdog
  // ---------------------------------------------------------------------------------

  // The driver offers the next queued event once the current one has been taken.
  // Between events it may leave the bus idle at random.
  always @(negedge clk) begin
    if (!rst && (!evt_valid || events_taken == events_offered)) begin
      if (bus_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = bus_backlog.pop_front();
        evt_valid <= 1'b1;
        evt_cmd   <= next_word.kind;
        evt_value <= next_word.value;
        evt_count <= next_word.count;
        events_offered = events_offered + 1;
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random. On request it holds off for a long stretch so
  // that the block's result register fills and the event input backs up.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      res_rdy   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_rdy   <= 1'b0;
    end else begin
      res_rdy <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Both handshakes are sampled at the rising edge. An accepted event updates the
  // mirror first, so its words are queued before any result word is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (evt_ch.valid && evt_ch.ready) begin
        step_sequencer(evt_ch.cmd, evt_ch.value, evt_ch.read_count);
        events_taken = events_taken + 1;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (owed_words.size() == 0) begin
          word_faults = word_faults + 1;
          if (word_faults <= SHOWN_FAULTS)
            $display("result word with none owed: data %02h status %0b last %0b",
                     res_ch.data_byte, res_ch.status, res_ch.last);
        end else begin
          due = owed_words.pop_front();
          if (res_ch.data_byte !== due.data_byte || res_ch.status !== due.status ||
              res_ch.last !== due.last) begin
            word_faults = word_faults + 1;
            if (word_faults <= SHOWN_FAULTS)
              $display("word mismatch: owed data %02h status %0b last %0b, got %02h %0b %0b",
                       due.data_byte, due.status, due.last,
                       res_ch.data_byte, res_ch.status, res_ch.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------

  task automatic queue_event(input logic [1:0] kind, input logic [7:0] v, input int n);
    bus_word_t w;
    w.kind  = kind;
    w.value = v;
    w.count = CNT_W'(n);
    bus_backlog.push_back(w);
    queued_events = queued_events + 1;
  endtask

  // Wait until every event has been taken and every owed word has come back. Then
  // let the block settle back into idle.
  task automatic drain();
    do @(negedge clk);
    while (bus_backlog.size() != 0 || events_taken != events_offered ||
           owed_words.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writes all four registers, one per cycle, and keeps the mirror in step. It is
  // only called when the block is idle.
  task automatic configure(input logic [7:0] manuf, input logic [7:0] device,
                           input logic rs_en, input logic wide);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MANUF_ID;
    cfg_data  <= manuf;
    @(negedge clk);
    cfg_index <= CFG_DEVICE_ID;
    cfg_data  <= device;
    @(negedge clk);
    cfg_index <= CFG_EXPECT_READ_START;
    cfg_data  <= {7'd0, rs_en};
    @(negedge clk);
    cfg_index <= CFG_WIDE_BUS;
    cfg_data  <= {7'd0, wide};
    @(negedge clk);
    cfg_we <= 1'b0;
    id_manuf      = manuf;
    id_device     = device;
    read_start_en = rs_en;
    wide_cells    = wide;
  endtask

  // Address bytes drawn from a few pages so that reads revisit programmed bytes.
  // Page 0xF0 reaches the end of the store, and random high bytes overrun it.
  // A few addresses run to three, four or an illegal fifth byte.
  task automatic queue_address();
    int         len, pick;
    logic [7:0] low, high;
    pick = $urandom_range(19);
    len  = (pick == 0) ? 1 : (pick < 15) ? 2 : (pick < 17) ? 3 : (pick < 19) ? 4 : 5;
    case ($urandom_range(7))
      0:       low = 8'($urandom_range(255));
      1:       low = 8'hFF;
      2:       low = 8'hF0;
      default: low = {3'($urandom_range(7)), 5'd0};
    endcase
    case ($urandom_range(4))
      0:       high = 8'h00;
      1:       high = 8'h01;
      2:       high = 8'h02;
      3:       high = 8'hF0;
      default: high = 8'($urandom_range(255));
    endcase
    queue_event(EV_ADDRESS, low, 0);
    if (len > 1) queue_event(EV_ADDRESS, high, 0);
    for (int k = 2; k < len; k++)
      queue_event(EV_ADDRESS, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00, 0);
  endtask

  // Mostly well-formed read, program and read id sequences with random content.
  // The rest is erase attempts and single random events.
  task automatic random_traffic(input int n_events);
    int unsigned target;
    int          pick, writes, n;
    target = queued_events + n_events;
    while (queued_events < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        queue_event(EV_COMMAND, OP_READ, 0);
        queue_address();
        case ($urandom_range(9))
          0, 1, 2, 3: queue_event(EV_COMMAND, OP_READ_START, 0);
          4:          queue_event(EV_COMMAND, 8'($urandom_range(255)), 0);
          default:    ;
        endcase
        // Burst lengths are mostly short. Zero, the full burst and oversized
        // counts turn up now and then.
        case ($urandom_range(19))
          0:             n = 0;
          1:             n = $urandom_range(63, 33);
          2:             n = MAX_BURST;
          3, 4, 5, 6, 7: n = $urandom_range(MAX_BURST, 1);
          default:       n = $urandom_range(8, 1);
        endcase
        queue_event(EV_READ, 8'($urandom_range(255)), n);
      end else if (pick < 65) begin
        queue_event(EV_COMMAND, OP_PROGRAM, 0);
        queue_address();
        writes = $urandom_range(6);
        repeat (writes) queue_event(EV_WRITE, 8'($urandom_range(255)), 0);
        case ($urandom_range(9))
          7:       queue_event(EV_COMMAND, 8'($urandom_range(255)), 0);
          8:       queue_event(EV_READ, 8'd0, $urandom_range(4));
          9:       ;
          default: queue_event(EV_COMMAND, OP_PROGRAM_END, 0);
        endcase
      end else if (pick < 75) begin
        queue_event(EV_COMMAND, OP_READID, 0);
        queue_event(EV_ADDRESS, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00, 0);
        if ($urandom_range(9) == 0) queue_event(EV_ADDRESS, 8'h00, 0);
        queue_event(EV_READ, 8'd0, $urandom_range(4));
      end else if (pick < 80) begin
        // Nothing gets past an erase but a reset.
        queue_event(EV_COMMAND, OP_ERASE, 0);
        queue_event(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom_range(63));
      end else begin
        queue_event(2'($urandom_range(3)),
                    ($urandom_range(7) == 0) ? OP_RESET : 8'($urandom_range(255)),
                    $urandom_range(63));
      end
    end
  endtask

  initial begin
    seq_to_idle();
    foreach (flash_image[i]) flash_image[i] = ERASED_BYTE;
    id_manuf      = MANUF_ID_RESET;
    id_device     = DEVICE_ID_RESET;
    read_start_en = 1'b0;
    wide_cells    = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The block sweeps its store after reset and takes no event until it is done.
    while (!evt_ch.ready) @(negedge clk);
    @(posedge clk);

    // Directed events under the reset register values.
    // A full burst of erased bytes from the first page.
    queue_event(EV_COMMAND, OP_READ, 0);
    queue_event(EV_ADDRESS, 8'h00, 0);
    queue_event(EV_ADDRESS, 8'h00, 0);
    queue_event(EV_READ, 8'h00, MAX_BURST);
    // Read id with both identifier bytes.
    queue_event(EV_COMMAND, OP_READID, 0);
    queue_event(EV_ADDRESS, 8'h00, 0);
    queue_event(EV_READ, 8'h00, 2);
    // Program the last byte of the store. The second write runs off the end.
    queue_event(EV_COMMAND, OP_PROGRAM, 0);
    queue_event(EV_ADDRESS, 8'hFF, 0);
    queue_event(EV_ADDRESS, 8'hF0, 0);
    queue_event(EV_WRITE, 8'h00, 0);
    queue_event(EV_WRITE, 8'hFF, 0);
    // A fifth address byte is refused.
    queue_event(EV_COMMAND, OP_READ, 0);
    repeat (5) queue_event(EV_ADDRESS, 8'h01, 0);
    // Erase cannot take its address.
    queue_event(EV_COMMAND, OP_ERASE, 0);
    queue_event(EV_ADDRESS, 8'h00, 0);
    // With read start disabled, a second command after read is out of order.
    queue_event(EV_COMMAND, OP_READ, 0);
    queue_event(EV_COMMAND, OP_READ_START, 0);
    // Stray events in idle: a burst with every count bit set, a write and an
    // unknown opcode.
    queue_event(EV_READ, 8'h00, 63);
    queue_event(EV_WRITE, 8'h55, 0);
    queue_event(EV_COMMAND, 8'h01, 0);
    drain();

    // The sender is mostly busy and the receiver mostly stalls.
    configure(8'hFF, 8'h00, 1'b1, 1'b0);
    @(posedge clk);
    random_traffic(80);
    drain();

    // The sender is mostly idle and the receiver mostly ready. Cells are 16 bits wide.
    configure(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, 1'b1);
    @(posedge clk);
    send_idle_pct = 76;
    recv_idle_pct = 20;
    random_traffic(80);
    drain();

    // No idling on either side. A long receiver hold-off at the start backs up the
    // event input while the sender keeps offering words.
    configure(8'h00, 8'hFF, 1'b1, 1'b1);
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(80);
    hold_req = hold_req + 1;
    drain();

    repeat (2 * SETTLE) @(negedge clk);
    if (word_faults == 0 && owed_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
